@@ hw/rtl/plvp_pkg.sv @@
`timescale 1ns / 1ps

package plvp_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int OUT_VAL_W = 32;
  localparam int OUT_CNT_W = 16;
  localparam int OUT_DATA_W = 56;

  localparam int GCNT_W = 4;
  localparam logic [GCNT_W-1:0] GROUP_CAP = 4'd10;

  localparam logic [7:0] STOP_RST     = 8'd128;
  localparam logic [7:0] CONTINUE_RST = 8'd131;
  localparam logic [7:0] META_RST     = 8'd129;
  localparam logic [7:0] POS_RST      = 8'd130;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_STOP       = 3'd0;
  localparam logic [2:0] REG_CONTINUE   = 3'd1;
  localparam logic [2:0] REG_META       = 3'd2;
  localparam logic [2:0] REG_POSITION   = 3'd3;
  localparam logic [2:0] REG_POS_ENABLE = 3'd4;
  localparam logic [2:0] REG_HIGH_FIRST = 3'd5;

  typedef enum logic [4:0] {
    PH_INDEX  = 5'b00001,
    PH_OCC    = 5'b00010,
    PH_RANK   = 5'b00100,
    PH_MARKER = 5'b01000,
    PH_LIST   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    LK_SKIP = 2'd0,
    LK_META = 2'd1,
    LK_POS  = 2'd2
  } list_kind_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INDEX     = 3'd0,
    KIND_OCC       = 3'd1,
    KIND_RANK      = 3'd2,
    KIND_META_ID   = 3'd3,
    KIND_POS_DELTA = 3'd4,
    KIND_ENTRY_END = 3'd5,
    KIND_LIST_END  = 3'd6
  } kind_t;

endpackage

@@ hw/rtl/posting_list_varint_parser.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata (lowest bit up)                         tuser
// s_axis    in         byte_in[7:0]                                  -
// m_axis    out        value[31:0], file_count[47:32], overflow[48]  kind[2:0]
// apb       cfg        six registers at byte addresses 0, 4, ... 20  -
//
// One byte is taken every cycle unless a result stalls; byte and result are each registered.
// The input register and the result register bound a single stage of decode
// logic, so throughput is set only by the output side's tready.
// Synchronous reset clears the parser state and loads the default markers.
// A stalled result holds the pipeline; one more byte can wait in the input register.

module posting_list_varint_parser #(
  parameter int VALUE_BITS = plvp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = plvp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // byte_in[7:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [plvp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // value, file_count, overflow
  output logic [plvp_pkg::KIND_W-1:0]     m_axis_tuser,  // kind
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plvp_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import plvp_pkg::*;

  logic [7:0] stop_byte;
  logic [7:0] continue_byte;
  logic [7:0] meta_list_byte;
  logic [7:0] position_list_byte;
  logic       position_enable;
  logic       high_group_first;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;

  phase_t                  phase, phase_next;
  logic [VALUE_BITS-1:0]   acc, acc_next;
  logic [GCNT_W-1:0]       gcnt, gcnt_next;
  logic                    sat, sat_next;
  list_kind_t              list_kind, list_kind_next;
  logic [COUNT_BITS-1:0]   entries, entries_next;

  logic [VALUE_BITS-1:0]   grp_acc;
  logic [GCNT_W-1:0]       grp_gcnt;
  logic                    grp_sat;
  logic                    grp_done;

  logic                    emit;
  kind_t                   emit_kind;
  logic [VALUE_BITS-1:0]   emit_val;
  logic [COUNT_BITS-1:0]   emit_cnt;
  logic                    emit_ov;
  logic [VALUE_BITS+31:0]  val_ext;
  logic [COUNT_BITS+15:0]  cnt_ext;

  logic                    wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_byte          <= STOP_RST;
      continue_byte      <= CONTINUE_RST;
      meta_list_byte     <= META_RST;
      position_list_byte <= POS_RST;
      position_enable    <= 1'b1;
      high_group_first   <= 1'b1;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_STOP:       stop_byte          <= pwdata[7:0];
        REG_CONTINUE:   continue_byte      <= pwdata[7:0];
        REG_META:       meta_list_byte     <= pwdata[7:0];
        REG_POSITION:   position_list_byte <= pwdata[7:0];
        REG_POS_ENABLE: position_enable    <= pwdata[0];
        REG_HIGH_FIRST: high_group_first   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_STOP:       prdata = {24'd0, stop_byte};
      REG_CONTINUE:   prdata = {24'd0, continue_byte};
      REG_META:       prdata = {24'd0, meta_list_byte};
      REG_POSITION:   prdata = {24'd0, position_list_byte};
      REG_POS_ENABLE: prdata = {31'd0, position_enable};
      REG_HIGH_FIRST: prdata = {31'd0, high_group_first};
      default:        prdata = 32'd0;
    endcase
  end

  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~in_valid | advance;
  assign step          = in_valid & advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  plvp_group #(
    .VALUE_BITS(VALUE_BITS)
  ) u_group (
    .acc        (acc),
    .gcnt       (gcnt),
    .sat        (sat),
    .byte_in    (in_byte),
    .high_first (high_group_first),
    .acc_next   (grp_acc),
    .gcnt_next  (grp_gcnt),
    .sat_next   (grp_sat),
    .done       (grp_done)
  );

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    gcnt_next      = gcnt;
    sat_next       = sat;
    list_kind_next = list_kind;
    entries_next   = entries;
    emit           = 1'b0;
    emit_kind      = KIND_INDEX;
    emit_val       = '0;
    emit_ov        = 1'b0;
    emit_cnt       = entries;

    if (phase == PH_MARKER) begin
      if (in_byte == stop_byte) begin
        emit         = 1'b1;
        emit_kind    = KIND_LIST_END;
        entries_next = '0;
        phase_next   = PH_INDEX;
      end else if (in_byte == continue_byte) begin
        emit       = 1'b1;
        emit_kind  = KIND_ENTRY_END;
        phase_next = PH_INDEX;
      end else begin
        if (in_byte == meta_list_byte) begin
          list_kind_next = LK_META;
        end else if (position_enable && in_byte == position_list_byte) begin
          list_kind_next = LK_POS;
        end else begin
          list_kind_next = LK_SKIP;
        end
        acc_next   = '0;
        gcnt_next  = '0;
        sat_next   = 1'b0;
        phase_next = PH_LIST;
      end
    end else if (phase == PH_LIST && gcnt == '0 && in_byte == stop_byte) begin
      phase_next = PH_MARKER;
    end else begin
      if (phase == PH_INDEX && gcnt == '0 && entries != '1) begin
        entries_next = entries + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
      emit_cnt  = entries_next;
      acc_next  = grp_acc;
      gcnt_next = grp_gcnt;
      sat_next  = grp_sat;
      if (grp_done) begin
        emit_val  = grp_acc;
        emit_ov   = grp_sat;
        acc_next  = '0;
        gcnt_next = '0;
        sat_next  = 1'b0;
        case (phase)
          PH_INDEX: begin
            emit       = 1'b1;
            emit_kind  = KIND_INDEX;
            phase_next = PH_OCC;
          end
          PH_OCC: begin
            emit       = 1'b1;
            emit_kind  = KIND_OCC;
            phase_next = PH_RANK;
          end
          PH_RANK: begin
            emit       = 1'b1;
            emit_kind  = KIND_RANK;
            phase_next = PH_MARKER;
          end
          PH_LIST: begin
            case (list_kind)
              LK_META: begin
                emit      = 1'b1;
                emit_kind = KIND_META_ID;
              end
              LK_POS: begin
                emit      = 1'b1;
                emit_kind = KIND_POS_DELTA;
              end
              default: ;
            endcase
          end
          default: phase_next = PH_INDEX;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_INDEX;
      acc       <= '0;
      gcnt      <= '0;
      sat       <= 1'b0;
      list_kind <= LK_SKIP;
      entries   <= '0;
    end else if (step) begin
      phase     <= phase_next;
      acc       <= acc_next;
      gcnt      <= gcnt_next;
      sat       <= sat_next;
      list_kind <= list_kind_next;
      entries   <= entries_next;
    end
  end

  assign val_ext = {32'd0, emit_val};
  assign cnt_ext = {16'd0, emit_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= step & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      m_axis_tdata <= {7'd0, emit_ov, cnt_ext[15:0], val_ext[31:0]};
      m_axis_tuser <= emit_kind;
    end
  end

  a_list_end_clears : assert property (@(posedge clk) disable iff (rst)
    (step && emit && emit_kind == KIND_LIST_END) |=> (entries == '0 && phase == PH_INDEX))
    else $error("list end did not clear the entry count");

  a_marker_idle : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MARKER) |-> (gcnt == '0 && !sat && acc == '0))
    else $error("marker phase entered with a partial value");

  a_overflow_kind : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[48]) |->
      (m_axis_tuser != KIND_ENTRY_END && m_axis_tuser != KIND_LIST_END))
    else $error("overflow flagged on a marker result");

endmodule

@@ hw/rtl/plvp_group.sv @@
`timescale 1ns / 1ps

module plvp_group #(
  parameter int VALUE_BITS = plvp_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0]       acc,
  input  logic [plvp_pkg::GCNT_W-1:0] gcnt,
  input  logic                        sat,
  input  logic [7:0]                  byte_in,
  input  logic                        high_first,
  output logic [VALUE_BITS-1:0]       acc_next,
  output logic [plvp_pkg::GCNT_W-1:0] gcnt_next,
  output logic                        sat_next,
  output logic                        done
);
  import plvp_pkg::*;

  logic [6:0]              grp;
  logic [6:0]              shamt;
  logic [VALUE_BITS+6:0]   grp_shifted;
  logic                    low_over;
  logic                    high_over;
  logic                    over;

  assign grp         = byte_in[6:0];
  assign shamt       = ({3'b000, gcnt} << 3) - {3'b000, gcnt};
  assign grp_shifted = {{VALUE_BITS{1'b0}}, grp} << shamt;
  assign high_over   = |acc[VALUE_BITS-1 -: 7];
  assign low_over    = (int'(shamt) >= VALUE_BITS) ? (grp != 7'd0)
                                                    : (|grp_shifted[VALUE_BITS+6:VALUE_BITS]);
  assign over        = high_first ? high_over : low_over;
  assign done        = ~byte_in[7];

  always_comb begin
    acc_next = acc;
    sat_next = sat;
    if (!sat) begin
      if (over) begin
        sat_next = 1'b1;
        acc_next = '1;
      end else if (high_first) begin
        acc_next = {acc[VALUE_BITS-8:0], grp};
      end else begin
        acc_next = acc | grp_shifted[VALUE_BITS-1:0];
      end
    end
    gcnt_next = (gcnt < GROUP_CAP) ? gcnt + 4'd1 : gcnt;
  end

endmodule

@@ tb/posting_list_varint_parser_tb.sv @@
`timescale 1ns / 1ps

module posting_list_varint_parser_tb;
  import plvp_pkg::*;

  localparam logic [63:0] VALUE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int HOLD_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [15:0] file_count;
    logic        overflow;
  } posting_result_t;

  // Tracks the parser state from accepted bytes and holds the results still owed.
  class posting_scoreboard;
    logic [7:0] stop_b, cont_b, meta_b, pos_b;
    logic pos_en, high_first;
    phase_t ph;
    logic [63:0] acc;
    int unsigned groups;
    bit sat;
    list_kind_t lk;
    logic [15:0] entries;
    posting_result_t expected[$];
    int unsigned failures;

    function new();
      stop_b = STOP_RST;
      cont_b = CONTINUE_RST;
      meta_b = META_RST;
      pos_b = POS_RST;
      pos_en = 1'b1;
      high_first = 1'b1;
      ph = PH_INDEX;
      lk = LK_SKIP;
      entries = '0;
      failures = 0;
      clear_value();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_STOP: stop_b = data[7:0];
        REG_CONTINUE: cont_b = data[7:0];
        REG_META: meta_b = data[7:0];
        REG_POSITION: pos_b = data[7:0];
        REG_POS_ENABLE: pos_en = data[0];
        REG_HIGH_FIRST: high_first = data[0];
        default: ;
      endcase
    endfunction

    function void clear_value();
      acc = '0;
      groups = 0;
      sat = 1'b0;
    endfunction

    function void push(kind_t k, logic [31:0] v, logic ov);
      posting_result_t r;
      r.kind = k;
      r.value = v;
      r.file_count = entries;
      r.overflow = ov;
      expected.insert(expected.size(), r);
    endfunction

    // Folds one 7-bit group into the running value; returns 1 on the last group.
    function bit add_group(logic [7:0] b);
      logic [63:0] g;
      int unsigned sh;
      g = {57'd0, b[6:0]};
      if (!sat) begin
        if (high_first) begin
          if (acc > (VALUE_MAX >> 7)) sat = 1'b1;
          else acc = (acc << 7) | g;
        end else begin
          sh = 7 * groups;
          if (sh >= 32) begin
            if (g != 0) sat = 1'b1;
          end else if (sh + 7 > 32 && (g >> (32 - sh)) != 0) begin
            sat = 1'b1;
          end else begin
            acc = acc | (g << sh);
          end
        end
        if (sat) acc = VALUE_MAX;
      end
      if (groups < 10) groups++;
      return !b[7];
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] v;
      logic ov;
      if (ph == PH_MARKER) begin
        if (b == stop_b) begin
          push(KIND_LIST_END, '0, 1'b0);
          entries = '0;
          ph = PH_INDEX;
        end else if (b == cont_b) begin
          push(KIND_ENTRY_END, '0, 1'b0);
          ph = PH_INDEX;
        end else begin
          if (b == meta_b) lk = LK_META;
          else if (pos_en && b == pos_b) lk = LK_POS;
          else lk = LK_SKIP;
          clear_value();
          ph = PH_LIST;
        end
        return;
      end
      if (ph == PH_LIST && groups == 0 && b == stop_b) begin
        ph = PH_MARKER;
        return;
      end
      if (ph == PH_INDEX && groups == 0 && entries != 16'hFFFF) entries++;
      if (!add_group(b)) return;
      v = acc[31:0];
      ov = sat;
      clear_value();
      case (ph)
        PH_INDEX: begin
          ph = PH_OCC;
          push(KIND_INDEX, v, ov);
        end
        PH_OCC: begin
          ph = PH_RANK;
          push(KIND_OCC, v, ov);
        end
        PH_RANK: begin
          ph = PH_MARKER;
          push(KIND_RANK, v, ov);
        end
        default: begin
          if (lk == LK_META) push(KIND_META_ID, v, ov);
          else if (lk == LK_POS) push(KIND_POS_DELTA, v, ov);
        end
      endcase
    endfunction

    function void check_result(kind_t k, logic [31:0] v, logic [15:0] fc, logic ov);
      posting_result_t want;
      if (expected.size() == 0) begin
        if (failures < 10)
          $display("Unexpected result: kind %0d value %h count %0d overflow %b",
                   k, v, fc, ov);
        failures++;
        return;
      end
      want = expected.pop_front();
      if (k !== want.kind || v !== want.value || fc !== want.file_count ||
          ov !== want.overflow) begin
        if (failures < 10)
          $display({"Mismatch: expected kind %0d value %h count %0d overflow %b, ",
                    "got kind %0d value %h count %0d overflow %b"},
                   want.kind, want.value, want.file_count, want.overflow, k, v, fc, ov);
        failures++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;  // byte_in[7:0]
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // value[31:0], file_count[47:32], overflow[48]
  logic [KIND_W-1:0] m_axis_tuser;  // kind[2:0]
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  posting_scoreboard sb;
  logic [7:0] stream[$];
  int send_idle;
  int recv_idle;
  bit hold_req;
  int stall_cycles;

  posting_list_varint_parser dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(kind_t'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tdata[47:32],
                      m_axis_tdata[48]);
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("posting_list_varint_parser_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The receiver takes a long break when asked, so the input side backs up.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream(int hold_at);
    for (int i = 0; i < stream.size(); i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_byte(stream[i]);
    end
    stream.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [7:0] stop_v, logic [7:0] cont_v, logic [7:0] meta_v,
                           logic [7:0] pos_v, logic en, logic hf);
    apb_write(REG_STOP, {24'd0, stop_v});
    apb_write(REG_CONTINUE, {24'd0, cont_v});
    apb_write(REG_META, {24'd0, meta_v});
    apb_write(REG_POSITION, {24'd0, pos_v});
    apb_write(REG_POS_ENABLE, {31'd0, en});
    apb_write(REG_HIGH_FIRST, {31'd0, hf});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A list integer never starts with the stop byte, or it would close the list.
  function automatic void put_int(bit in_list);
    int n, sel;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 65) n = $urandom_range(1, 3);
    else if (sel < 88) n = $urandom_range(4, 5);
    else n = $urandom_range(6, 12);
    for (int i = 0; i < n; i++) begin
      b = {(i != n - 1), 7'($urandom_range(127))};
      if (in_list && i == 0 && b == sb.stop_b) b[0] = ~b[0];
      stream.insert(stream.size(), b);
    end
  endfunction

  function automatic void put_entry(bit last);
    int subs, vals, sel;
    logic [7:0] m;
    for (int i = 0; i < 3; i++) put_int(1'b0);
    subs = $urandom_range(0, 3);
    for (int s = 0; s < subs; s++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        m = sb.meta_b;
      end else if (sel < 80) begin
        m = sb.pos_b;
      end else begin
        do m = 8'($urandom_range(255)); while (m == sb.stop_b || m == sb.cont_b);
      end
      stream.insert(stream.size(), m);
      vals = $urandom_range(0, 4);
      for (int k = 0; k < vals; k++) put_int(1'b1);
      stream.insert(stream.size(), sb.stop_b);
    end
    stream.insert(stream.size(), last ? sb.stop_b : sb.cont_b);
  endfunction

  // Mostly whole lists with random content, some raw noise and cut-off entries.
  function automatic void fill_random(int target);
    int sel, n;
    while (stream.size() < target) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        n = $urandom_range(1, 4);
        for (int e = 0; e < n; e++) put_entry(e == n - 1);
      end else if (sel < 95) begin
        n = $urandom_range(1, 6);
        repeat (n) stream.insert(stream.size(), 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) put_int(1'b0);
      end
    end
  endfunction

  initial begin
    logic [7:0] d_stop, d_cont, d_meta;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    send_idle = 17;
    recv_idle = 62;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Default markers, most significant group first.
    stream = {8'h7F,
              8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
              8'h90, 8'h80, 8'h80, 8'h80, 8'h00,
              8'h81, 8'h00, 8'h81, 8'h80, 8'h00, 8'h80,
              8'h82, 8'h81, 8'h00, 8'h80,
              8'h55, 8'h05, 8'h80,
              8'h83,
              8'h00, 8'h01, 8'h02, 8'h80};
    send_stream(-1);
    fill_random(320);
    send_stream(120);
    drain();

    // Least significant group first, position lists disabled, continue equal to meta.
    send_idle = 62;
    recv_idle = 17;
    configure(8'h00, 8'hFF, 8'hFF, 8'h40, 1'b0, 1'b0);
    stream = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10,
              8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
              8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01,
              8'h40, 8'h03, 8'h00, 8'hFF};
    send_stream(-1);
    fill_random(300);
    send_stream(-1);
    drain();

    // Position marker equal to the stop byte.
    send_idle = 0;
    recv_idle = 0;
    configure(8'hFF, 8'h00, 8'h7F, 8'hFF, 1'b1, 1'b0);
    fill_random(150);
    send_stream(-1);
    drain();

    // Random distinct markers with meta and position sharing one value.
    d_stop = 8'($urandom_range(255));
    do d_cont = 8'($urandom_range(255)); while (d_cont == d_stop);
    do d_meta = 8'($urandom_range(255)); while (d_meta == d_stop || d_meta == d_cont);
    configure(d_stop, d_cont, d_meta, d_meta, 1'b1, 1'b1);
    fill_random(150);
    send_stream(-1);
    drain();

    // Back to the default markers.
    configure(STOP_RST, CONTINUE_RST, META_RST, POS_RST, 1'b1, 1'b1);
    fill_random(100);
    send_stream(-1);
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("posting_list_varint_parser_tb OK");
    end else begin
      $display("posting_list_varint_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
